// ===== hdl/arwk_pkg.sv =====
// shared types, constants and helpers for the ar archive header walker
// no dependencies; imported by arwk_out_reg and ar_archive_header_walker
package arwk_pkg;

    // stream and header geometry
    localparam int OFFSET_BITS  = 32;
    localparam int HEADER_BYTES = 60;
    localparam int MAGIC_BYTES  = 8;

    // header field start positions
    localparam int F_TIME  = 16;
    localparam int F_OWNER = 28;
    localparam int F_GROUP = 34;
    localparam int F_MODE  = 40;
    localparam int F_SIZE  = 48;
    localparam int F_MARK0 = 58;

    // characters
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_MARK0 = 8'h60;
    localparam logic [7:0] CH_MARK1 = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // result kinds
    typedef enum logic [1:0] {
        KIND_MEMBER    = 2'd0,
        KIND_END       = 2'd1,
        KIND_BAD_MAGIC = 2'd2,
        KIND_BAD_MARK  = 2'd3
    } t_kind;

    // input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    // result item
    typedef struct packed {
        t_kind       kind;
        logic [31:0] header_offset;
        logic [33:0] data_size;
        logic [39:0] mod_time;
        logic [19:0] owner_id;
        logic [19:0] group_id;
        logic [23:0] file_mode;
        logic        final_res;
    } t_out_item;

    // expected archive magic "!<arch>\n"
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h21;
            3'd1:    v = 8'h3C;
            3'd2:    v = 8'h61;
            3'd3:    v = 8'h72;
            3'd4:    v = 8'h63;
            3'd5:    v = 8'h68;
            3'd6:    v = 8'h3E;
            default: v = 8'h0A;
        endcase
        return v;
    endfunction

    // white space as skipped before a number
    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic is_dec(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_oct(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h37);
    endfunction

endpackage

// ===== hdl/arwk_out_reg.sv =====
// result register between the parser and the output channel
// depends on arwk_pkg for the result item type
module arwk_out_reg
    import arwk_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_item,
    input  logic      i_out_stall,
    output logic      o_free,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    logic      r_valid;
    t_out_item r_item;

    // register can take a new item when empty or being drained
    assign o_free = !r_valid || !i_out_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_item <= i_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

// ===== hdl/ar_archive_header_walker.sv =====
// ar archive header walker: magic check, member header parse, data skip
// depends on arwk_pkg and arwk_out_reg
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------
//   in      | input     | i_in_valid / o_in_stall | t_in_item
//   out     | output    | o_out_valid / i_out_stall | t_out_item
//
// one byte is taken per cycle while the output register is free; each byte
// updates the parse state and any result lands in the output register at the same edge.
// a stalled output register blocks input only while it holds an item.
// reset is synchronous and active low; the block starts in the magic check.
// a byte flagged last always yields a result and returns the parser to reset.
module ar_archive_header_walker
    import arwk_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    typedef enum logic [3:0] {
        PH_MAGIC  = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_STOP   = 4'b1000
    } t_phase;

    t_phase                 r_phase,   n_phase;
    logic [5:0]             r_pos,     n_pos;
    logic [34:0]            r_skip,    n_skip;
    logic [OFFSET_BITS-1:0] r_region,  n_region;
    logic                   r_first,   n_first;
    logic                   r_index,   n_index;
    logic                   r_started, n_started;
    logic                   r_stopped, n_stopped;
    logic [33:0]            r_size,    n_size;
    logic [39:0]            r_time,    n_time;
    logic [19:0]            r_owner,   n_owner;
    logic [19:0]            r_group,   n_group;
    logic [23:0]            r_mode,    n_mode;
    logic                   r_mark,    n_mark;

    logic      in_acc;
    logic      out_free;
    logic      res_valid;
    t_out_item res_item;

    assign o_in_stall = !out_free;
    assign in_acc     = i_in_valid && out_free;

    // parse step for one byte
    always_comb begin
        logic [7:0]  b;
        logic        fs;
        logic        blank;
        logic        dig_ok;
        logic [3:0]  d;
        logic [34:0] padded;

        b      = i_in_item.data_byte;
        d      = 4'(b - CH_ZERO);
        blank  = is_blank(b);
        fs     = 1'b0;
        dig_ok = 1'b0;
        padded = '0;

        n_phase   = r_phase;
        n_pos     = r_pos;
        n_skip    = r_skip;
        n_region  = r_region;
        n_first   = r_first;
        n_index   = r_index;
        n_started = r_started;
        n_stopped = r_stopped;
        n_size    = r_size;
        n_time    = r_time;
        n_owner   = r_owner;
        n_group   = r_group;
        n_mode    = r_mode;
        n_mark    = r_mark;

        res_valid = 1'b0;
        res_item  = '0;

        case (r_phase)
            PH_MAGIC: begin
                if ((r_pos >= 6'(MAGIC_BYTES)) || (b != magic_byte(r_pos[2:0]))) begin
                    res_valid     = 1'b1;
                    res_item.kind = KIND_BAD_MAGIC;
                    n_phase       = PH_STOP;
                end else if (r_pos == 6'(MAGIC_BYTES - 1)) begin
                    n_phase = PH_HEADER;
                    n_pos   = '0;
                end else begin
                    n_pos = r_pos + 6'd1;
                end
            end
            PH_HEADER: begin
                // new header clears accumulators and flags
                if (r_pos == 6'd0) begin
                    n_size  = '0;
                    n_time  = '0;
                    n_owner = '0;
                    n_group = '0;
                    n_mode  = '0;
                    n_index = 1'b0;
                    n_mark  = 1'b0;
                end
                fs = (r_pos == 6'(F_TIME))  || (r_pos == 6'(F_OWNER)) ||
                     (r_pos == 6'(F_GROUP)) || (r_pos == 6'(F_MODE))  ||
                     (r_pos == 6'(F_SIZE));
                if (fs) begin
                    n_started = 1'b0;
                    n_stopped = 1'b0;
                end
                dig_ok = (r_pos >= 6'(F_MODE) && r_pos < 6'(F_SIZE)) ? is_oct(b) : is_dec(b);

                if (r_pos < 6'(F_TIME)) begin
                    // long-name index shows as a name starting with two slashes
                    if (r_first && r_pos == 6'd0) begin
                        n_index = (b == CH_SLASH);
                    end else if (r_first && r_pos == 6'd1) begin
                        n_index = r_index && (b == CH_SLASH);
                    end
                end else if (r_pos < 6'(F_MARK0)) begin
                    // number field: skip leading blanks, stop at a non-digit
                    if (!n_stopped && !(!n_started && blank)) begin
                        n_started = 1'b1;
                        if (!dig_ok) begin
                            n_stopped = 1'b1;
                        end else if (r_pos < 6'(F_OWNER)) begin
                            n_time = (r_time << 3) + (r_time << 1) + 40'(d);
                        end else if (r_pos < 6'(F_GROUP)) begin
                            n_owner = (r_owner << 3) + (r_owner << 1) + 20'(d);
                        end else if (r_pos < 6'(F_MODE)) begin
                            n_group = (r_group << 3) + (r_group << 1) + 20'(d);
                        end else if (r_pos < 6'(F_SIZE)) begin
                            n_mode = (r_mode << 3) + 24'(d);
                        end else begin
                            n_size = (r_size << 3) + (r_size << 1) + 34'(d);
                        end
                    end
                end else if (r_pos == 6'(F_MARK0)) begin
                    n_mark = (b == CH_MARK0);
                end

                // last header byte: check marks, report (but not a leading long-name index), set up data skip
                if (r_pos == 6'(HEADER_BYTES - 1)) begin
                    n_pos = '0;
                    if (r_mark && (b == CH_MARK1)) begin
                        padded = {1'b0, r_size} + 35'(r_size[0]);
                        if (!(r_first && r_index)) begin
                            res_valid              = 1'b1;
                            res_item.kind          = KIND_MEMBER;
                            res_item.header_offset = 32'(r_region);
                            res_item.data_size     = r_size;
                            res_item.mod_time      = r_time;
                            res_item.owner_id      = r_owner;
                            res_item.group_id      = r_group;
                            res_item.file_mode     = r_mode;
                            n_region = r_region + OFFSET_BITS'(HEADER_BYTES)
                                       + OFFSET_BITS'(padded);
                        end
                        n_first = 1'b0;
                        n_skip  = padded;
                        n_phase = (padded != '0) ? PH_DATA : PH_HEADER;
                    end else begin
                        res_valid     = 1'b1;
                        res_item.kind = KIND_BAD_MARK;
                        n_phase       = PH_STOP;
                    end
                end else begin
                    n_pos = r_pos + 6'd1;
                end
            end
            PH_DATA: begin
                n_skip = r_skip - 35'd1;
                if (r_skip == 35'd1) begin
                    n_phase = PH_HEADER;
                end
            end
            PH_STOP: begin
                n_phase = PH_STOP;
            end
            default: begin
                n_phase = PH_STOP;
            end
        endcase

        // end of stream closes the result and rearms the parser
        if (i_in_item.last) begin
            if (!res_valid) begin
                res_valid     = 1'b1;
                res_item.kind = (n_phase == PH_MAGIC) ? KIND_BAD_MAGIC : KIND_END;
            end
            res_item.final_res = 1'b1;
            n_phase   = PH_MAGIC;
            n_pos     = '0;
            n_skip    = '0;
            n_region  = '0;
            n_first   = 1'b1;
            n_index   = 1'b0;
            n_started = 1'b0;
            n_stopped = 1'b0;
            n_size    = '0;
            n_time    = '0;
            n_owner   = '0;
            n_group   = '0;
            n_mode    = '0;
            n_mark    = 1'b0;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MAGIC;
            r_pos     <= '0;
            r_skip    <= '0;
            r_region  <= '0;
            r_first   <= 1'b1;
            r_index   <= 1'b0;
            r_started <= 1'b0;
            r_stopped <= 1'b0;
            r_size    <= '0;
            r_time    <= '0;
            r_owner   <= '0;
            r_group   <= '0;
            r_mode    <= '0;
            r_mark    <= 1'b0;
        end else if (in_acc) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_skip    <= n_skip;
            r_region  <= n_region;
            r_first   <= n_first;
            r_index   <= n_index;
            r_started <= n_started;
            r_stopped <= n_stopped;
            r_size    <= n_size;
            r_time    <= n_time;
            r_owner   <= n_owner;
            r_group   <= n_group;
            r_mode    <= n_mode;
            r_mark    <= n_mark;
        end
    end

    // result register
    arwk_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_acc && res_valid),
        .i_item      (res_item),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // checks on the parse state
    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.last) |=> (r_phase == PH_MAGIC) && (r_pos == 6'd0) && r_first)
        else $error("parser not rearmed after last item");

    a_last_gives_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.last) |=> (o_out_valid && o_out_item.final_res))
        else $error("last item did not leave a final result");

    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_pos < 6'(HEADER_BYTES)))
        else $error("header byte position out of range");

    a_data_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_skip != '0))
        else $error("data phase with nothing left to skip");

    a_stop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (r_phase == PH_STOP) && !i_in_item.last) |-> !res_valid)
        else $error("result raised after a stop");

endmodule
